// ===== hw/rtl/cau_pkg.sv =====
// Package for the complex arithmetic unit: opcodes, payload types and pipeline constants.
package cau_pkg;

  localparam int unsigned OpW = 3;

  typedef enum logic [OpW-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_DIST = 3'd4
  } op_t;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               div_zero;
  } out_item_t;

  // Quotient magnitude bits produced by the divider chain (one cell per bit).
  localparam int unsigned QBits = 52;
  // Dividend magnitude width: |n| < 2^32, shifted left by 16.
  localparam int unsigned NumW = 49;
  // Divisor width: b_re^2 + b_im^2 <= 2^31.
  localparam int unsigned DenW = 32;
  // Square root radicand is S << 16 with S < 2^35, so 51 bits; 26 root bits.
  localparam int unsigned RootBits = 26;
  localparam int unsigned RadW = 2 * RootBits;
  // Cells in the chain: one per quotient bit covers the root bits too.
  localparam int unsigned NCells = QBits;

  // Data handed from one cell of the chain to the next.
  typedef struct packed {
    logic               vld;
    logic [OpW-1:0]     op;
    logic               dz;
    logic               neg_re;
    logic               neg_im;
    logic [NumW-1:0]    num_re;   // remaining dividend bits, shifted in from the top
    logic [NumW-1:0]    num_im;
    logic [DenW:0]      rem_re;   // partial remainders
    logic [DenW:0]      rem_im;
    logic [DenW-1:0]    den;
    logic [QBits-1:0]   q_re;
    logic [QBits-1:0]   q_im;
    logic [RadW-1:0]    rad;      // radicand, two bits consumed per root-enabled cell
    logic [RootBits+1:0] srem;    // root remainder
    logic [RootBits-1:0] root;
    logic signed [31:0] fast_re;  // add, subtract, multiply, unused results
    logic signed [31:0] fast_im;
  } stage_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/cau_front.sv =====
// Front stages: products, fast results and the start of the divide and root chain.
module cau_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_in,
  input  cau_pkg::in_item_t item,
  output cau_pkg::stage_t   stg
);

  // First stage: products and differences.
  logic                vld1_r;
  logic [2:0]          op1_r;
  logic signed [31:0]  p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  logic signed [16:0]  sum_re_r, sum_im_r, dx_r, dy_r;
  logic signed [31:0]  p_rr_nxt, p_ii_nxt, p_ir_nxt, p_ri_nxt;

  always_comb begin
    p_rr_nxt = 32'(item.a_re * item.b_re);
    p_ii_nxt = 32'(item.a_im * item.b_im);
    p_ir_nxt = 32'(item.a_im * item.b_re);
    p_ri_nxt = 32'(item.a_re * item.b_im);
  end

  // Multipliers for squares: b squares in the first stage, dx and dy squares in the second.
  logic signed [31:0]  bb_re_r, bb_im_r;
  logic [33:0]         dxx_r, dyy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld_in;
    end
    op1_r    <= item.op;
    p_rr_r   <= p_rr_nxt;
    p_ii_r   <= p_ii_nxt;
    p_ir_r   <= p_ir_nxt;
    p_ri_r   <= p_ri_nxt;
    bb_re_r  <= 32'(item.b_re * item.b_re);
    bb_im_r  <= 32'(item.b_im * item.b_im);
    sum_re_r <= (item.op == cau_pkg::OP_ADD) ? 17'(item.a_re) + 17'(item.b_re)
                                             : 17'(item.a_re) - 17'(item.b_re);
    sum_im_r <= (item.op == cau_pkg::OP_ADD) ? 17'(item.a_im) + 17'(item.b_im)
                                             : 17'(item.a_im) - 17'(item.b_im);
    dx_r     <= 17'(item.a_re) - 17'(item.b_re);
    dy_r     <= 17'(item.a_im) - 17'(item.b_im);
  end

  logic signed [17:0]  dx_ext, dy_ext;
  always_comb begin
    dx_ext = 18'(dx_r);
    dy_ext = 18'(dy_r);
  end

  // Radicand: sum of the squared differences.
  logic [34:0]         s_sum;

  always_comb begin
    s_sum = 35'(dxx_r) + 35'(dyy_r);
  end

  // dx^2 is formed in its own register, then the stage above sums it.
  logic               vld2_r;
  logic [2:0]         op2_r;
  logic signed [31:0] p_rr2_r, p_ii2_r, p_ir2_r, p_ri2_r, bb_re2_r, bb_im2_r;
  logic signed [16:0] sum_re2_r, sum_im2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    op2_r     <= op1_r;
    p_rr2_r   <= p_rr_r;
    p_ii2_r   <= p_ii_r;
    p_ir2_r   <= p_ir_r;
    p_ri2_r   <= p_ri_r;
    bb_re2_r  <= bb_re_r;
    bb_im2_r  <= bb_im_r;
    sum_re2_r <= sum_re_r;
    sum_im2_r <= sum_im_r;
    dxx_r     <= 34'(dx_ext * dx_ext);
    dyy_r     <= 34'(dy_ext * dy_ext);
  end

  // The sums use the second-stage copies so that squares and products line up.
  logic signed [32:0]  n2_s, m2_s;
  logic signed [63:0]  w2_re, w2_im;
  always_comb begin
    n2_s  = 33'(p_rr2_r) + 33'(p_ii2_r);
    m2_s  = 33'(p_ir2_r) - 33'(p_ri2_r);
    w2_re = '0;
    w2_im = '0;
    case (op2_r)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        w2_re = 64'(sum_re2_r) <<< 8;
        w2_im = 64'(sum_im2_r) <<< 8;
      end
      cau_pkg::OP_MUL: begin
        w2_re = 64'(p_rr2_r) - 64'(p_ii2_r);
        w2_im = 64'(p_ir2_r) + 64'(p_ri2_r);
      end
      default: begin
        w2_re = '0;
        w2_im = '0;
      end
    endcase
  end

  logic [31:0] n2_mag, m2_mag;
  logic [31:0] den2;
  always_comb begin
    n2_mag = n2_s[32] ? 32'(-n2_s) : n2_s[31:0];
    m2_mag = m2_s[32] ? 32'(-m2_s) : m2_s[31:0];
    den2   = 32'(33'(bb_re2_r) + 33'(bb_im2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg.vld <= 1'b0;
    end else begin
      stg.vld <= vld2_r;
    end
    stg.op      <= op2_r;
    stg.dz      <= (op2_r == cau_pkg::OP_DIV) && (den2 == '0);
    stg.neg_re  <= n2_s[32];
    stg.neg_im  <= m2_s[32];
    // The chain appends three zero bits after these, so the dividend it sees is |n| << 16.
    stg.num_re  <= {4'd0, n2_mag, 13'd0};
    stg.num_im  <= {4'd0, m2_mag, 13'd0};
    stg.rem_re  <= '0;
    stg.rem_im  <= '0;
    stg.den     <= den2;
    stg.q_re    <= '0;
    stg.q_im    <= '0;
    stg.rad     <= {1'b0, s_sum, 16'd0};
    stg.srem    <= '0;
    stg.root    <= '0;
    stg.fast_re <= cau_pkg::sat32(w2_re);
    stg.fast_im <= cau_pkg::sat32(w2_im);
  end

endmodule

// ===== hw/rtl/cau_cell.sv =====
// One cell of the chain: one restoring quotient bit for each part, one root bit when root_en is set.
module cau_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            root_en,
  input  cau_pkg::stage_t d_in,
  output cau_pkg::stage_t d_out
);

  localparam int unsigned DW = cau_pkg::DenW;
  localparam int unsigned RB = cau_pkg::RootBits;

  logic [DW:0]   tr_re, tr_im;
  logic [DW+1:0] sub_re, sub_im;
  logic [RB+1:0] tsr, tsub;
  logic [RB+1:0] trial;
  cau_pkg::stage_t nxt;

  always_comb begin
    nxt    = d_in;
    // Shift the next dividend bit into each remainder.
    tr_re  = {d_in.rem_re[DW-1:0], d_in.num_re[cau_pkg::NumW-1]};
    tr_im  = {d_in.rem_im[DW-1:0], d_in.num_im[cau_pkg::NumW-1]};
    sub_re = {1'b0, tr_re} - {2'b0, d_in.den};
    sub_im = {1'b0, tr_im} - {2'b0, d_in.den};
    nxt.num_re = {d_in.num_re[cau_pkg::NumW-2:0], 1'b0};
    nxt.num_im = {d_in.num_im[cau_pkg::NumW-2:0], 1'b0};
    nxt.rem_re = sub_re[DW+1] ? tr_re : sub_re[DW:0];
    nxt.rem_im = sub_im[DW+1] ? tr_im : sub_im[DW:0];
    nxt.q_re   = {d_in.q_re[cau_pkg::QBits-2:0], ~sub_re[DW+1]};
    nxt.q_im   = {d_in.q_im[cau_pkg::QBits-2:0], ~sub_im[DW+1]};
    // Digit-by-digit square root: bring down two radicand bits.
    tsr   = {d_in.srem[RB-1:0], d_in.rad[cau_pkg::RadW-1 -: 2]};
    trial = {d_in.root, 2'b01};
    tsub  = tsr - trial;
    if (root_en) begin
      nxt.rad  = {d_in.rad[cau_pkg::RadW-3:0], 2'b00};
      nxt.srem = (tsr >= trial) ? tsub : tsr;
      nxt.root = {d_in.root[RB-2:0], (tsr >= trial)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_out.vld <= 1'b0;
    end else begin
      d_out.vld <= nxt.vld;
    end
    d_out.op      <= nxt.op;
    d_out.dz      <= nxt.dz;
    d_out.neg_re  <= nxt.neg_re;
    d_out.neg_im  <= nxt.neg_im;
    d_out.num_re  <= nxt.num_re;
    d_out.num_im  <= nxt.num_im;
    d_out.rem_re  <= nxt.rem_re;
    d_out.rem_im  <= nxt.rem_im;
    d_out.den     <= nxt.den;
    d_out.q_re    <= nxt.q_re;
    d_out.q_im    <= nxt.q_im;
    d_out.rad     <= nxt.rad;
    d_out.srem    <= nxt.srem;
    d_out.root    <= nxt.root;
    d_out.fast_re <= nxt.fast_re;
    d_out.fast_im <= nxt.fast_im;
  end

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit: add, subtract, multiply, divide and distance on Q8.8 operands.
// Pipeline: the front registers, a register in each of the 52 divider cells, then the output register.
// Throughput: one operation per cycle; busy stays low, items enter back to back.
// The divide and square root run as a chain of cells, one quotient bit per cell.
// Reset (synchronous, active low) clears all valid bits; no result strobes after it.
// The receiver cannot stall; each result is shown for one cycle with out_valid.
module complex_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cau_pkg::in_item_t  in_item,
  output logic               out_valid,
  output cau_pkg::out_item_t out_item
);

  localparam int unsigned N = cau_pkg::NCells;
  localparam int unsigned RB = cau_pkg::RootBits;

  cau_pkg::stage_t chain [N+1];

  assign busy = 1'b0;

  cau_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (start),
    .item   (in_item),
    .stg    (chain[0])
  );

  // The root needs only the first RootBits cells; later cells pass it along.
  for (genvar g = 0; g < N; g++) begin : g_cell
    cau_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .root_en (1'(g < RB)),
      .d_in    (chain[g]),
      .d_out   (chain[g+1])
    );
  end

  cau_pkg::stage_t    last;
  logic signed [63:0] qs_re, qs_im;
  cau_pkg::out_item_t res_nxt;

  always_comb begin
    last   = chain[N];
    qs_re  = last.neg_re ? -64'(last.q_re) : 64'(last.q_re);
    qs_im  = last.neg_im ? -64'(last.q_im) : 64'(last.q_im);
    res_nxt.div_zero = 1'b0;
    res_nxt.res_re   = last.fast_re;
    res_nxt.res_im   = last.fast_im;
    case (last.op)
      cau_pkg::OP_DIV: begin
        res_nxt.div_zero = last.dz;
        res_nxt.res_re   = last.dz ? '0 : cau_pkg::sat32(qs_re);
        res_nxt.res_im   = last.dz ? '0 : cau_pkg::sat32(qs_im);
      end
      cau_pkg::OP_DIST: begin
        res_nxt.res_re = 32'(last.root);
        res_nxt.res_im = '0;
      end
      default: begin
        res_nxt.res_re = last.fast_re;
        res_nxt.res_im = last.fast_im;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= last.vld;
    end
    out_item <= res_nxt;
  end

endmodule

// ===== hw/rtl/cau_checker.sv =====
// Port-level checker for the complex arithmetic unit, bound to the top level.
module cau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input cau_pkg::out_item_t out_item
);

  a_never_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");

  a_dz_only_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.div_zero) |-> (out_item.res_re == '0 && out_item.res_im == '0))
    else $error("divide by zero result not zero");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("strobe after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##56 out_valid)
    else $error("result missing");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
